// File: rtl/ledmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ledmq_pkg
// Shared constants and types of the LED marquee frame generator.
// ----------------------------------------------------------------------------
package ledmq_pkg;

    localparam int LED_COUNT = 64;
    localparam int PIX_W     = 6;
    localparam int COLOR_W   = 24;

    localparam logic [PIX_W-1:0] LED_LAST = PIX_W'(LED_COUNT - 1);

    // Register indexes of the configuration port
    localparam logic [2:0] REG_START_COLOR  = 3'd0;
    localparam logic [2:0] REG_END_COLOR    = 3'd1;
    localparam logic [2:0] REG_CYCLE_COUNT  = 3'd2;
    localparam logic [2:0] REG_DIRECTION    = 3'd3;
    localparam logic [2:0] REG_KEEP_MODE    = 3'd4;
    localparam logic [2:0] REG_WINDOW_WIDTH = 3'd5;

    // Effect phase codes; the unused code behaves as the opening frame
    localparam logic [1:0] PH_OPEN  = 2'd0;
    localparam logic [1:0] PH_SWEEP = 2'd1;
    localparam logic [1:0] PH_FINAL = 2'd2;
    localparam logic [1:0] PH_SPARE = 2'd3;

    // Per-frame setup handed from the controller to the pixel pipeline
    typedef struct packed {
        logic [1:0]         phase;
        logic               keep;
        logic [PIX_W-1:0]   lo;
        logic [PIX_W-1:0]   hi;
        logic [PIX_W-1:0]   center;
        logic [PIX_W-1:0]   half;
        logic [COLOR_W-1:0] start_color;
        logic [COLOR_W-1:0] end_color;
        logic [COLOR_W-1:0] blend_color;
    } ledmq_frame_t;

endpackage

// File: rtl/ledmq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ledmq_ctrl
// Configuration registers, effect sequencer and per-frame setup.
// ----------------------------------------------------------------------------
module ledmq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [23:0]           cfg_data,
    input  logic                  req_valid,
    input  logic                  req_restart,
    output logic                  req_ready,
    input  logic                  frame_done,
    output logic                  frame_start,
    output ledmq_pkg::ledmq_frame_t frame
);
    import ledmq_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SETUP1, ST_SETUP2, ST_RUN} state_t;

    state_t             state_reg;
    logic [23:0]        start_color_reg;
    logic [23:0]        end_color_reg;
    logic [15:0]        cycle_count_reg;
    logic               direction_reg;
    logic               keep_mode_reg;
    logic [6:0]         window_width_reg;

    logic [1:0]         phase_reg;
    logic [15:0]        cycle_reg;
    logic [6:0]         step_reg;

    logic               restart_reg;
    logic [1:0]         fphase_reg;
    logic [15:0]        cyc_reg;
    logic [15:0]        c_reg;
    logic [PIX_W-1:0]   half_reg;
    logic [PIX_W-1:0]   endp_reg;
    logic [23:0]        mid_reg;
    logic               frame_start_reg;
    ledmq_frame_t       frame_reg;

    // first setup step
    logic [1:0]         fphase_next;
    logic [15:0]        cyc_next;
    logic [15:0]        c_next;
    logic [6:0]         w_eff;
    logic [PIX_W-1:0]   endp_next;
    logic [23:0]        mid_next;

    // second setup step
    logic [6:0]         flow;
    logic [6:0]         step_cl;
    logic [6:0]         step_inc;
    logic [15:0]        cyc_inc;
    logic [PIX_W-1:0]   center;
    logic [PIX_W-1:0]   lo;
    logic [PIX_W-1:0]   hi;

    always_comb
    begin
        fphase_next = (restart_reg || phase_reg == PH_SPARE) ? PH_OPEN : phase_reg;
        cyc_next    = (cycle_count_reg == 16'd0) ? 16'd1 : cycle_count_reg;
        c_next      = (cycle_reg >= cyc_next) ? cyc_next - 16'd1 : cycle_reg;
        if (window_width_reg == 7'd0)
            w_eff = 7'd3;
        else if (window_width_reg > 7'(LED_COUNT))
            w_eff = 7'(LED_COUNT);
        else
            w_eff = window_width_reg;
        if (keep_mode_reg)
        begin
            if (!direction_reg)
                endp_next = (c_next > 16'(LED_LAST)) ? '0 : LED_LAST - c_next[PIX_W-1:0];
            else
                endp_next = (c_next > 16'(LED_LAST)) ? LED_LAST : c_next[PIX_W-1:0];
        end
        else
        begin
            endp_next = direction_reg ? '0 : LED_LAST;
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            mid_next[ch*8 +: 8] = 8'((9'(start_color_reg[ch*8 +: 8])
                                   + 9'(end_color_reg[ch*8 +: 8])) >> 1);
        end
    end

    always_comb
    begin
        if (!direction_reg)
        begin
            flow = {1'b0, endp_reg} + 7'd1;
            lo   = endp_reg;
            hi   = LED_LAST;
        end
        else
        begin
            flow = 7'(LED_COUNT) - {1'b0, endp_reg};
            lo   = '0;
            hi   = endp_reg;
        end
        step_cl  = (step_reg >= flow) ? flow - 7'd1 : step_reg;
        center   = direction_reg ? LED_LAST - step_cl[PIX_W-1:0] : step_cl[PIX_W-1:0];
        step_inc = step_cl + 7'd1;
        cyc_inc  = c_reg + 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_color_reg  <= 24'hFFFFFF;
            end_color_reg    <= 24'hD200D2;
            cycle_count_reg  <= 16'd60;
            direction_reg    <= 1'b0;
            keep_mode_reg    <= 1'b1;
            window_width_reg <= 7'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_COLOR:  start_color_reg  <= cfg_data;
                REG_END_COLOR:    end_color_reg    <= cfg_data;
                REG_CYCLE_COUNT:  cycle_count_reg  <= cfg_data[15:0];
                REG_DIRECTION:    direction_reg    <= cfg_data[0];
                REG_KEEP_MODE:    keep_mode_reg    <= cfg_data[0];
                REG_WINDOW_WIDTH: window_width_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_OPEN;
            cycle_reg       <= '0;
            step_reg        <= '0;
            restart_reg     <= 1'b0;
            fphase_reg      <= PH_OPEN;
            cyc_reg         <= '0;
            c_reg           <= '0;
            half_reg        <= '0;
            endp_reg        <= '0;
            mid_reg         <= '0;
            frame_reg       <= '0;
            frame_start_reg <= 1'b0;
        end
        else
        begin
            frame_start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        restart_reg <= req_restart;
                        state_reg   <= ST_SETUP1;
                    end
                end
                ST_SETUP1:
                begin
                    fphase_reg <= fphase_next;
                    cyc_reg    <= cyc_next;
                    c_reg      <= c_next;
                    half_reg   <= w_eff[PIX_W:1];
                    endp_reg   <= endp_next;
                    mid_reg    <= mid_next;
                    state_reg  <= ST_SETUP2;
                end
                ST_SETUP2:
                begin
                    frame_reg.phase       <= fphase_reg;
                    frame_reg.keep        <= keep_mode_reg;
                    frame_reg.lo          <= lo;
                    frame_reg.hi          <= hi;
                    frame_reg.center      <= center;
                    frame_reg.half        <= half_reg;
                    frame_reg.start_color <= start_color_reg;
                    frame_reg.end_color   <= end_color_reg;
                    frame_reg.blend_color <= mid_reg;
                    case (fphase_reg)
                        PH_SWEEP:
                        begin
                            if (step_inc >= flow)
                            begin
                                step_reg  <= '0;
                                cycle_reg <= cyc_inc;
                                if (cyc_inc >= cyc_reg)
                                    phase_reg <= keep_mode_reg ? PH_FINAL : PH_OPEN;
                                else
                                    phase_reg <= PH_SWEEP;
                            end
                            else
                            begin
                                step_reg  <= step_inc;
                                phase_reg <= PH_SWEEP;
                            end
                        end
                        PH_FINAL:
                        begin
                            phase_reg <= PH_OPEN;
                        end
                        default:
                        begin
                            phase_reg <= PH_SWEEP;
                            cycle_reg <= '0;
                            step_reg  <= '0;
                        end
                    endcase
                    frame_start_reg <= 1'b1;
                    state_reg       <= ST_RUN;
                end
                ST_RUN:
                begin
                    if (frame_done)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req_ready   = (state_reg == ST_IDLE);
    assign frame_start = frame_start_reg;
    assign frame       = frame_reg;

endmodule

// File: rtl/ledmq_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ledmq_pixel
// Pixel store with read-modify-write pipeline and output register.
// ----------------------------------------------------------------------------
module ledmq_pixel (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    frame_start,
    input  ledmq_pkg::ledmq_frame_t frame,
    output logic                    frame_done,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,
    output logic                    m_tlast
);
    import ledmq_pkg::*;

    logic [COLOR_W-1:0] store_mem [LED_COUNT];

    logic [PIX_W:0]     issue_cnt_reg;
    logic               rd_valid_reg;
    logic [PIX_W-1:0]   rd_idx_reg;
    logic [COLOR_W-1:0] rd_data_reg;
    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_idx_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_last_reg;

    logic               adv;
    logic               rd_en;
    logic               wr_en;
    logic [6:0]         diff;
    logic [6:0]         offset_mag;
    logic               in_window;
    logic               is_center;
    logic               retained;
    logic [COLOR_W-1:0] win_color;
    logic [COLOR_W-1:0] new_color;

    assign adv   = !out_valid_reg || m_tready;
    assign rd_en = (issue_cnt_reg < (PIX_W+1)'(LED_COUNT)) && (adv || !rd_valid_reg);
    assign wr_en = adv && rd_valid_reg;

    always_comb
    begin
        diff       = {1'b0, rd_idx_reg} - {1'b0, frame.center};
        offset_mag = diff[6] ? 7'd0 - diff : diff;
        in_window  = offset_mag <= {1'b0, frame.half};
        is_center  = rd_idx_reg == frame.center;
        retained   = (rd_idx_reg >= frame.lo) && (rd_idx_reg <= frame.hi);
        win_color  = is_center ? frame.end_color : frame.blend_color;
        case (frame.phase)
            PH_SWEEP:
            begin
                if (frame.keep)
                begin
                    if (retained)
                        new_color = frame.end_color;
                    else if (in_window)
                        new_color = win_color;
                    else
                        new_color = rd_data_reg;
                end
                else
                begin
                    new_color = in_window ? win_color : frame.start_color;
                end
            end
            PH_FINAL: new_color = frame.end_color;
            default:  new_color = frame.start_color;
        endcase
    end

    // pixel store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[rd_idx_reg] <= new_color;
        if (rd_en)
            rd_data_reg <= store_mem[issue_cnt_reg[PIX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= (PIX_W+1)'(LED_COUNT);
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_start)
                issue_cnt_reg <= '0;
            else if (rd_en)
                issue_cnt_reg <= issue_cnt_reg + (PIX_W+1)'(1);
            if (rd_en)
                rd_valid_reg <= 1'b1;
            else if (adv)
                rd_valid_reg <= 1'b0;
            if (adv)
                out_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_idx_reg <= issue_cnt_reg[PIX_W-1:0];
        if (wr_en)
        begin
            out_idx_reg   <= rd_idx_reg;
            out_color_reg <= new_color;
            out_last_reg  <= rd_idx_reg == LED_LAST;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {2'b00, out_color_reg[7:0], out_color_reg[15:8],
                         out_color_reg[23:16], out_idx_reg};
    assign m_tlast    = out_last_reg;
    assign frame_done = out_valid_reg && m_tready && out_last_reg;

endmodule

// File: rtl/led_marquee_frame_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_marquee_frame_generator
// Running-light animation frame generator for a 64-pixel LED strip.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the slave stream (s_tdata bit 0 = restart) asks for the
//   next animation frame. The block answers with 64 pixels on the master
//   stream in index order, m_tlast marking the final pixel. Configuration
//   registers are written through cfg_we/cfg_index/cfg_data, by the user only
//   while the block is idle (s_tready high); the block does not enforce it.
// Pipeline and throughput:
//   After a request is accepted, the first pixel passes the two setup
//   steps, read issue, store read and the output register. Pixels then
//   stream at one per cycle while m_tready is high, set by the single read
//   and write port of the pixel store, and s_tready returns the cycle after
//   the last pixel is taken.
// Reset:
//   Registers return to their defaults and the effect resumes at the
//   opening frame. The pixel store is not cleared: the opening frame
//   always paints every pixel before any stored value is shown.
// Stall:
//   With m_tready low, hold the output pixel; the pipeline holds its read
//   data and stops issuing reads until the output register frees up.
// ----------------------------------------------------------------------------
module led_marquee_frame_generator (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    // frame requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    // pixel results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [5:0] pixel_index, [13:6] red, [21:14] green,
                                   // [29:22] blue, [31:30] zero
    output logic        m_tlast    // frame_last
);
    import ledmq_pkg::*;

    ledmq_frame_t frame;
    logic         frame_start;
    logic         frame_done;

    // sequencer: advance effect state and latch per-frame setup
    ledmq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_valid   (s_tvalid),
        .req_restart (s_tdata[0]),
        .req_ready   (s_tready),
        .frame_done  (frame_done),
        .frame_start (frame_start),
        .frame       (frame)
    );

    // pixel store read-modify-write and output stream
    ledmq_pixel u_pixel (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_start (frame_start),
        .frame       (frame),
        .frame_done  (frame_done),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// File: rtl/ledmq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ledmq_checker
// Port-level checks of the LED marquee frame generator.
// ----------------------------------------------------------------------------
module ledmq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // a stalled pixel holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled pixel changed");

    // no request is taken while a frame is still on the output
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("request ready while pixels pending");

    // an accepted request makes the block busy
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after accepted request");

    // mid-frame the block stays busy, and the frame ends on the last pixel
    a_busy_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !s_tready)
        else $error("ready before frame end");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[5:0] == 6'd63)
        else $error("frame end not on last pixel");

endmodule

bind led_marquee_frame_generator ledmq_checker u_ledmq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
